FILE: rtl/sre_pkg.sv
// Shared types and fixed constants for the sample rate estimator.
// No dependencies; used by sample_rate_estimator and sre_div.
`default_nettype none

package sre_pkg;

    // Widths fixed by the arithmetic
    localparam int DEN_W       = 40;     // divisor and remainder width
    localparam int MST_W       = 48;     // long-term sample total
    localparam int MTT_W       = 40;     // long-term time total
    localparam int MRATE_W     = 41;     // mean rate, saturates at 2^40
    localparam int NOM_W       = 18;
    localparam int MAXP_W      = 24;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int MEAN_SH     = 5;      // mean totals are kept times 32

    localparam logic [16:0] WINDOW_US   = 17'd100000;
    localparam logic [39:0] DECAY_LIMIT = 40'd512000000;  // 16 s times 32
    localparam logic [39:0] MTT_INIT    = 40'd384000000;  // 12 s times 32
    localparam logic [8:0]  MST_INIT_K  = 9'd384;         // 12 times 32
    localparam logic [17:0] NOM_RESET   = 18'd48000;
    localparam logic [23:0] MAXP_RESET  = 24'd100000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DROP,
        S_PUSH,
        S_CHECK,
        S_WDIV,
        S_POP,
        S_MQ,
        S_MQW,
        S_MUL1,
        S_MUL2,
        S_MR,
        S_MRW,
        S_EST,
        S_DECAY,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/sre_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on sre_pkg for the divisor width.
`default_nettype none

module sre_div #(
    parameter int DW = 69
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [DW-1:0]                 i_num,
    input  wire [sre_pkg::DEN_W-1:0]     i_den,
    output logic                         o_busy,
    output logic [DW-1:0]                o_quot,
    output logic [sre_pkg::DEN_W-1:0]    o_rem
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]               r_q, n_q;
    logic [sre_pkg::DEN_W-1:0]   r_rem, n_rem;
    logic [sre_pkg::DEN_W-1:0]   r_den;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic [sre_pkg::DEN_W:0]     trial;

    // One trial subtract per cycle; dividend shifts out as quotient shifts in
    always_comb begin
        trial = {r_rem, r_q[DW-1]};
        if (trial >= {1'b0, r_den}) begin
            n_rem = sre_pkg::DEN_W'(trial - {1'b0, r_den});
            n_q   = {r_q[DW-2:0], 1'b1};
        end else begin
            n_rem = trial[sre_pkg::DEN_W-1:0];
            n_q   = {r_q[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: rtl/sample_rate_estimator.sv
// Sample rate estimator top level: window queue, long-term mean, IIR estimate.
// Depends on sre_pkg and sre_div.
`default_nettype none

// One result item per input item. A feed that only records its time (first
// feed, long gap) goes straight to the output step. A used feed drops the
// oldest entry when the queue is full, pushes the new entry and then, for each
// window entry popped, runs the window rate division and, when the entry enters
// the long-term mean, one or two mean divisions and the estimate update. The
// divider width is DW = 41 + bits of 1e6*RATE_SCALE (66 at the defaults). The
// output step waits while the previous result is stalled. All divisions run on
// one shared bit-serial divider; the input is stalled while an item is worked
// on. The window queue has no clearing after reset: only pushed entries are
// ever read.

module sample_rate_estimator #(
    parameter int QUEUE_DEPTH = 16,
    parameter int RATE_SCALE  = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // input channel
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire  [15:0]                   i_sample_count,
    input  wire  [31:0]                   i_timestamp_us,
    // output channel
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic [22:0]                   o_rate_estimate,
    output logic                          o_estimate_updated,
    // configuration
    input  wire                           i_cfg_we,
    input  wire  [sre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [sre_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam longint unsigned K    = 64'd1000000 * RATE_SCALE;
    localparam int KW                = $clog2(K + 1);
    localparam int DW                = sre_pkg::DEN_W + KW + 1;
    localparam int EW                = $clog2(RATE_SCALE + 1);
    localparam int RW                = sre_pkg::NOM_W + EW;
    localparam int QPW               = $clog2(QUEUE_DEPTH + 1);
    localparam int HW                = $clog2(QUEUE_DEPTH);
    localparam int SSW               = 16 + QPW;
    localparam int TSW               = 32 + QPW;
    localparam longint unsigned CAPQ = (64'd1 << 40) / K;
    localparam int CW                = $clog2(CAPQ + 1);
    localparam int MRW               = sre_pkg::MRATE_W;
    localparam int VW                = ((RW + 5) > MRW ? (RW + 5) : MRW) + 1;
    localparam int HALF              = sre_pkg::DEN_W / 2;

    localparam logic [KW-1:0]  KV  = KW'(K);
    localparam logic [DW-1:0]  CQV = DW'(CAPQ);
    localparam logic [MRW-1:0] CAP = MRW'(64'd1 << 40);

    sre_pkg::t_state r_state, n_state;

    // configuration
    logic [sre_pkg::NOM_W-1:0]  r_nominal;
    logic [sre_pkg::MAXP_W-1:0] r_maxp;

    // window queue
    logic [15:0]      mem_s [QUEUE_DEPTH];
    logic [31:0]      mem_t [QUEUE_DEPTH];
    logic [15:0]      r_rd_s;
    logic [31:0]      r_rd_t;
    logic [HW-1:0]    r_head;
    logic [QPW-1:0]   r_fill;
    logic [SSW-1:0]   r_ssum;
    logic [TSW-1:0]   r_tsum;

    // estimator state
    logic [sre_pkg::MST_W-1:0] r_mst;
    logic [sre_pkg::MTT_W-1:0] r_mtt;
    logic [RW-1:0]             r_sm;
    logic [31:0]               r_prev;

    // per-item work registers
    logic [15:0]      r_count;
    logic [31:0]      r_now;
    logic [31:0]      r_gap;
    logic             r_use;
    logic             r_upd;
    logic [CW-1:0]    r_q;
    logic [sre_pkg::DEN_W-1:0] r_rem;
    logic [DW-1:0]    r_prod;
    logic [MRW-1:0]   r_mrate;

    // output register
    logic             r_o_valid;
    logic [22:0]      r_o_rate;
    logic             r_o_upd;

    // divider
    logic                      div_start;
    logic [DW-1:0]             div_num;
    logic [sre_pkg::DEN_W-1:0] div_den;
    logic                      div_busy;
    logic [DW-1:0]             div_quot;
    logic [sre_pkg::DEN_W-1:0] div_rem;

    // derived values
    logic [RW-1:0]             ref_rate;
    logic [RW-1:0]             ref_hi;
    logic [RW-1:0]             ref_lo;
    logic [sre_pkg::MTT_W-1:0] mt1;
    logic [31:0]               gap;
    logic                      feed_ok;
    logic                      pop_more;
    logic                      in_acc;
    logic                      out_free;
    logic [DW-1:0]             win_diff;
    logic [HW:0]               tail_sum;
    logic [HW-1:0]             tail;
    logic [HW-1:0]             head_nx;
    logic [DW:0]               est_sum;
    logic [VW-1:0]             v_sum;
    logic [VW-1:0]             v_shr;
    logic [RW-1:0]             v_clamp;
    logic [sre_pkg::MST_W:0]   mst_add;
    logic [sre_pkg::MTT_W:0]   mtt_add;
    logic [sre_pkg::MST_W+1:0] mst_dec;
    logic [sre_pkg::MTT_W+1:0] mtt_dec;

    always_comb begin
        ref_rate = RW'(r_nominal * RATE_SCALE);
        ref_hi   = ref_rate + (ref_rate >> 6);
        ref_lo   = ref_rate - (ref_rate >> 6);
        mt1      = (r_mtt == '0) ? sre_pkg::MTT_W'(1) : r_mtt;
        gap      = i_timestamp_us - r_prev;
        feed_ok  = (r_prev != '0) && (gap < {8'd0, r_maxp});
        pop_more = (r_tsum > TSW'(sre_pkg::WINDOW_US)) && (r_fill != '0);
        in_acc   = i_valid && (r_state == sre_pkg::S_IDLE);
        out_free = !r_o_valid || !i_stall;

        // queue pointers
        tail_sum = {1'b0, r_head} + (HW+1)'(r_fill);
        tail     = (tail_sum >= (HW+1)'(QUEUE_DEPTH))
                   ? HW'(tail_sum - (HW+1)'(QUEUE_DEPTH)) : tail_sum[HW-1:0];
        head_nx  = (r_head == HW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

        // window rate distance from nominal
        win_diff = (div_quot > DW'(ref_rate)) ? div_quot - DW'(ref_rate)
                                               : DW'(ref_rate) - div_quot;

        // mean rate from quotient pieces
        est_sum  = (DW+1)'(r_q) * KV + {1'b0, div_quot};

        // IIR step and clamp
        v_sum    = (VW'(r_sm) << 5) - VW'(r_sm) + VW'(r_mrate) + VW'(16);
        v_shr    = v_sum >> 5;
        if (v_shr > VW'(ref_hi)) begin
            v_clamp = ref_hi;
        end else if (v_shr < VW'(ref_lo)) begin
            v_clamp = ref_lo;
        end else begin
            v_clamp = v_shr[RW-1:0];
        end

        // mean accumulation and decay
        mst_add = {1'b0, r_mst} + ((sre_pkg::MST_W+1)'(r_rd_s) << sre_pkg::MEAN_SH);
        mtt_add = {1'b0, r_mtt} + ((sre_pkg::MTT_W+1)'(r_rd_t) << sre_pkg::MEAN_SH);
        mst_dec = (((sre_pkg::MST_W+2)'(r_mst) << 1) + (sre_pkg::MST_W+2)'(r_mst)
                  + (sre_pkg::MST_W+2)'(2)) >> 2;
        mtt_dec = (((sre_pkg::MTT_W+2)'(r_mtt) << 1) + (sre_pkg::MTT_W+2)'(r_mtt)
                  + (sre_pkg::MTT_W+2)'(2)) >> 2;
    end

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = mt1;
        case (r_state)
            sre_pkg::S_CHECK: begin
                div_start = pop_more;
                div_num   = DW'(r_ssum) * KV;
                div_den   = sre_pkg::DEN_W'(r_tsum);
            end
            sre_pkg::S_MQ: begin
                div_start = 1'b1;
                div_num   = DW'(r_mst);
            end
            sre_pkg::S_MR: begin
                div_start = 1'b1;
                div_num   = r_prod;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    sre_div #(
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sre_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            sre_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (!feed_ok) begin
                        n_state = sre_pkg::S_OUT;
                    end else if (r_fill >= QPW'(QUEUE_DEPTH)) begin
                        n_state = sre_pkg::S_DROP;
                    end else begin
                        n_state = sre_pkg::S_PUSH;
                    end
                end
            end
            sre_pkg::S_DROP:  n_state = sre_pkg::S_PUSH;
            sre_pkg::S_PUSH:  n_state = sre_pkg::S_CHECK;
            sre_pkg::S_CHECK: n_state = pop_more ? sre_pkg::S_WDIV : sre_pkg::S_OUT;
            sre_pkg::S_WDIV: begin
                if (!div_busy) begin
                    n_state = sre_pkg::S_POP;
                end
            end
            sre_pkg::S_POP:   n_state = r_use ? sre_pkg::S_MQ : sre_pkg::S_CHECK;
            sre_pkg::S_MQ:    n_state = sre_pkg::S_MQW;
            sre_pkg::S_MQW: begin
                if (!div_busy) begin
                    n_state = (div_quot >= CQV) ? sre_pkg::S_EST : sre_pkg::S_MUL1;
                end
            end
            sre_pkg::S_MUL1:  n_state = sre_pkg::S_MUL2;
            sre_pkg::S_MUL2:  n_state = sre_pkg::S_MR;
            sre_pkg::S_MR:    n_state = sre_pkg::S_MRW;
            sre_pkg::S_MRW: begin
                if (!div_busy) begin
                    n_state = sre_pkg::S_EST;
                end
            end
            sre_pkg::S_EST:   n_state = sre_pkg::S_DECAY;
            sre_pkg::S_DECAY: n_state = sre_pkg::S_CHECK;
            sre_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = sre_pkg::S_IDLE;
                end
            end
            default:          n_state = sre_pkg::S_IDLE;
        endcase
    end

    // window queue storage; head entry read every cycle
    always_ff @(posedge i_clk) begin
        if (r_state == sre_pkg::S_PUSH) begin
            mem_s[tail] <= r_count;
            mem_t[tail] <= r_gap;
        end
        r_rd_s <= mem_s[r_head];
        r_rd_t <= mem_t[r_head];
    end

    // control state: queue pointers, sums, estimator, output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal <= sre_pkg::NOM_RESET;
            r_maxp    <= sre_pkg::MAXP_RESET;
            r_head    <= '0;
            r_fill    <= '0;
            r_ssum    <= '0;
            r_tsum    <= '0;
            r_mst     <= sre_pkg::MST_W'(sre_pkg::NOM_RESET) * sre_pkg::MST_INIT_K;
            r_mtt     <= sre_pkg::MTT_INIT;
            r_sm      <= RW'(sre_pkg::NOM_RESET * RATE_SCALE);
            r_prev    <= '0;
            r_upd     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // output valid: set when a result is loaded, cleared when taken
            if (r_state == sre_pkg::S_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                sre_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_upd <= 1'b0;
                    end
                end
                sre_pkg::S_DROP, sre_pkg::S_POP: begin
                    r_ssum <= r_ssum - SSW'(r_rd_s);
                    r_tsum <= r_tsum - TSW'(r_rd_t);
                    r_head <= head_nx;
                    r_fill <= r_fill - 1'b1;
                    if (r_state == sre_pkg::S_POP && r_use) begin
                        r_mst <= mst_add[sre_pkg::MST_W] ? '1 : mst_add[sre_pkg::MST_W-1:0];
                        r_mtt <= mtt_add[sre_pkg::MTT_W] ? '1 : mtt_add[sre_pkg::MTT_W-1:0];
                    end
                end
                sre_pkg::S_PUSH: begin
                    r_ssum <= r_ssum + SSW'(r_count);
                    r_tsum <= r_tsum + TSW'(r_gap);
                    r_fill <= r_fill + 1'b1;
                end
                sre_pkg::S_EST: begin
                    r_sm  <= v_clamp;
                    r_upd <= 1'b1;
                end
                sre_pkg::S_DECAY: begin
                    if (r_mtt > sre_pkg::DECAY_LIMIT) begin
                        r_mst <= mst_dec[sre_pkg::MST_W-1:0];
                        r_mtt <= mtt_dec[sre_pkg::MTT_W-1:0];
                    end
                end
                sre_pkg::S_OUT: begin
                    if (out_free) begin
                        r_prev <= r_now;
                    end
                end
                default: begin
                end
            endcase

            // configuration writes must arrive only while idle; the block does not enforce it
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sre_pkg::CFG_NOMINAL: begin
                        r_nominal <= i_cfg_data[sre_pkg::NOM_W-1:0];
                        r_sm      <= RW'(i_cfg_data[sre_pkg::NOM_W-1:0] * RATE_SCALE);
                        r_mst     <= sre_pkg::MST_W'(i_cfg_data[sre_pkg::NOM_W-1:0])
                                     * sre_pkg::MST_INIT_K;
                        r_mtt     <= sre_pkg::MTT_INIT;
                        r_prev    <= '0;
                    end
                    sre_pkg::CFG_MAX_PERIOD: begin
                        r_maxp <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            sre_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_count <= i_sample_count;
                    r_now   <= i_timestamp_us;
                    r_gap   <= gap;
                end
            end
            sre_pkg::S_WDIV: begin
                r_use <= win_diff < DW'(ref_rate >> 1);
            end
            sre_pkg::S_MQW: begin
                r_q     <= div_quot[CW-1:0];
                r_rem   <= div_rem;
                r_mrate <= CAP;
            end
            sre_pkg::S_MUL1: begin
                r_prod <= DW'(r_rem[sre_pkg::DEN_W-1:HALF]) * KV;
            end
            sre_pkg::S_MUL2: begin
                r_prod <= (r_prod << HALF) + DW'(r_rem[HALF-1:0]) * KV + DW'(mt1 >> 1);
            end
            sre_pkg::S_MRW: begin
                r_mrate <= (est_sum > (DW+1)'(CAP)) ? CAP : MRW'(est_sum);
            end
            sre_pkg::S_OUT: begin
                if (out_free) begin
                    r_o_rate <= 23'(r_sm);
                    r_o_upd  <= r_upd;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stall            = (r_state != sre_pkg::S_IDLE);
    assign o_valid            = r_o_valid;
    assign o_rate_estimate    = r_o_rate;
    assign o_estimate_updated = r_o_upd;

endmodule

`default_nettype wire
